### rtl/core/dbw_pkg.sv
// Shared constants and types for the depth back-projection pipeline.
`timescale 1ns / 1ps

package dbw_pkg;

    localparam int NUM_KEYPOINTS = 16;

    // magnitude of (u - cx) * z and width of the focal length divisor
    localparam int NUM_W = 32;
    localparam int DEN_W = 24;

    typedef enum logic [2:0] {
        CFG_FOCAL_LENGTHS   = 3'd0,
        CFG_PRINCIPAL_POINT = 3'd1,
        CFG_ROTATION_ROW_A  = 3'd2,
        CFG_ROTATION_ROW_B  = 3'd3,
        CFG_ROTATION_ROW_C  = 3'd4,
        CFG_TRANSLATION_CM  = 3'd5,
        CFG_WORLD_MODE      = 3'd6
    } t_cfg_index;

    localparam logic [47:0] FOCAL_RST = 48'h0000_1000_0010;
    localparam logic [31:0] PP_RST    = 32'h0000_0000;
    localparam logic [47:0] ROT_A_RST = 48'h0000_0000_4000;
    localparam logic [47:0] ROT_B_RST = 48'h0000_4000_0000;
    localparam logic [47:0] ROT_C_RST = 48'h4000_0000_0000;
    localparam logic [47:0] TRANS_RST = 48'h0000_0000_0000;

    localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] COORD_MIN = -24'sh800000;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
    } t_div_lane;

    typedef struct packed {
        logic        ok;
        logic [3:0]  idx;
        logic        neg_x;
        logic        neg_y;
        logic        zero_x;
        logic        zero_y;
        logic [15:0] z;
    } t_side;

    typedef struct packed {
        logic       ok;
        logic [3:0] idx;
    } t_tail;

endpackage

### rtl/core/depth_backprojection_to_world.sv
// Top level: pinhole back-projection of a keypoint with optional rigid transform.
`timescale 1ns / 1ps

// Keypoint requests enter on the input channel (i_in_valid / o_in_ready) with an
// index, a Q12.4 pixel position and a depth in mm. Each request gives exactly one
// result request on the output channel (o_out_valid / i_out_ready): index, a valid
// flag (depth nonzero and index in range) and x, y, z in mm saturated to 24 bits.
// The datapath is a 40-stage pipeline: one request per cycle while o_in_ready is
// high, and each result is registered on the output.
// Depth is set by the two 32-step restoring dividers (one quotient bit per stage)
// for x / fx and y / fy; two stages ahead of them form offsets and numerators, and
// rounding, rotation, translation and saturation take six more after them.
// Each stage has its own valid bit and loads when it is empty or its successor
// moves, so bubbles close up and new requests are taken while a result waits.
// If the receiver stalls with every stage full, o_in_ready drops; nothing is lost.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) go to seven
// registers by index and must only happen when no request is in flight.
// A synchronous active-low reset empties the pipeline and restores the default
// configuration: unit focal lengths, zero principal point, identity rotation,
// zero translation, camera mode.
module depth_backprojection_to_world (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [3:0]          i_joint_index,
    input  logic [15:0]         i_pixel_u,
    input  logic [15:0]         i_pixel_v,
    input  logic [15:0]         i_depth_mm,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [3:0]          o_point_index,
    output logic                o_point_valid,
    output logic signed [23:0]  o_coord_x_mm,
    output logic signed [23:0]  o_coord_y_mm,
    output logic signed [23:0]  o_coord_z_mm
);

    localparam int NDIV = dbw_pkg::NUM_W;

    // configuration
    logic [47:0] r_focal;
    logic [31:0] r_pp;
    logic [47:0] r_rot [3];
    logic [47:0] r_trans;
    logic        r_world;

    logic [dbw_pkg::DEN_W-1:0] fx;
    logic [dbw_pkg::DEN_W-1:0] fy;

    assign o_cfg_ready = 1'b1;
    assign fx = r_focal[23:0];
    assign fy = r_focal[47:24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= dbw_pkg::FOCAL_RST;
            r_pp     <= dbw_pkg::PP_RST;
            r_rot[0] <= dbw_pkg::ROT_A_RST;
            r_rot[1] <= dbw_pkg::ROT_B_RST;
            r_rot[2] <= dbw_pkg::ROT_C_RST;
            r_trans  <= dbw_pkg::TRANS_RST;
            r_world  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (dbw_pkg::t_cfg_index'(i_cfg_index))
                dbw_pkg::CFG_FOCAL_LENGTHS:   r_focal  <= i_cfg_data;
                dbw_pkg::CFG_PRINCIPAL_POINT: r_pp     <= i_cfg_data[31:0];
                dbw_pkg::CFG_ROTATION_ROW_A:  r_rot[0] <= i_cfg_data;
                dbw_pkg::CFG_ROTATION_ROW_B:  r_rot[1] <= i_cfg_data;
                dbw_pkg::CFG_ROTATION_ROW_C:  r_rot[2] <= i_cfg_data;
                dbw_pkg::CFG_TRANSLATION_CM:  r_trans  <= i_cfg_data;
                dbw_pkg::CFG_WORLD_MODE:      r_world  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // helpers
    function automatic dbw_pkg::t_div_lane div_step(dbw_pkg::t_div_lane a,
                                                    logic [dbw_pkg::DEN_W-1:0] den);
        logic [dbw_pkg::DEN_W:0] trial;
        logic [dbw_pkg::DEN_W:0] diff;
        logic                    qbit;
        dbw_pkg::t_div_lane      res;
        trial = {a.rem, a.num[dbw_pkg::NUM_W-1]};
        diff  = trial - {1'b0, den};
        qbit  = (trial >= {1'b0, den});
        res.rem = qbit ? diff[dbw_pkg::DEN_W-1:0] : trial[dbw_pkg::DEN_W-1:0];
        res.num = {a.num[dbw_pkg::NUM_W-2:0], qbit};
        return res;
    endfunction

    // round half away from zero, apply sign; a zero divisor saturates by sign
    function automatic logic signed [33:0] div_finish(dbw_pkg::t_div_lane a,
                                                      logic [dbw_pkg::DEN_W-1:0] den,
                                                      logic neg, logic zero);
        logic                rup;
        logic [32:0]         q;
        logic signed [33:0]  s;
        rup = ({a.rem, 1'b0} >= {1'b0, den});
        q   = {1'b0, a.num} + {32'd0, rup};
        s   = signed'({1'b0, q});
        if (den == '0) begin
            if (zero) begin
                s = '0;
            end else if (neg) begin
                s = 34'(dbw_pkg::COORD_MIN);
            end else begin
                s = 34'(dbw_pkg::COORD_MAX);
            end
        end else if (neg) begin
            s = -s;
        end
        return s;
    endfunction

    function automatic logic signed [23:0] sat24(logic signed [38:0] v);
        logic signed [23:0] res;
        if (v > 39'(dbw_pkg::COORD_MAX)) begin
            res = dbw_pkg::COORD_MAX;
        end else if (v < 39'(dbw_pkg::COORD_MIN)) begin
            res = dbw_pkg::COORD_MIN;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    // pipeline registers
    logic               r_p1_vld;
    logic               r_p1_ok;
    logic [3:0]         r_p1_idx;
    logic [15:0]        r_p1_adx;
    logic [15:0]        r_p1_ady;
    logic               r_p1_sx;
    logic               r_p1_sy;
    logic [15:0]        r_p1_z;

    logic               r_dv_vld  [NDIV+1];
    dbw_pkg::t_side     r_dv_side [NDIV+1];
    dbw_pkg::t_div_lane r_dv_x    [NDIV+1];
    dbw_pkg::t_div_lane r_dv_y    [NDIV+1];

    logic               r_rd_vld;
    dbw_pkg::t_tail     r_rd_tail;
    logic signed [33:0] r_rd_c [3];

    logic               r_w1_vld;
    dbw_pkg::t_tail     r_w1_tail;
    logic signed [33:0] r_w1_c [3];
    logic signed [49:0] r_w1_p [3][3];

    logic               r_w2_vld;
    dbw_pkg::t_tail     r_w2_tail;
    logic signed [33:0] r_w2_c [3];
    logic signed [51:0] r_w2_s [3];
    logic signed [19:0] r_w2_t10 [3];

    logic               r_w3_vld;
    dbw_pkg::t_tail     r_w3_tail;
    logic signed [33:0] r_w3_c [3];
    logic signed [37:0] r_w3_r [3];
    logic signed [19:0] r_w3_t10 [3];

    logic               r_w4_vld;
    dbw_pkg::t_tail     r_w4_tail;
    logic signed [38:0] r_w4_v [3];

    logic               r_out_vld;
    dbw_pkg::t_tail     r_out_tail;
    logic signed [23:0] r_out_c [3];

    // stage load enables: a stage loads when empty or when its successor moves
    logic en_out, en_w4, en_w3, en_w2, en_w1, en_rd, en_p1;
    logic en_dv [NDIV+1];

    assign en_out = !r_out_vld || i_out_ready;
    assign en_w4  = !r_w4_vld  || en_out;
    assign en_w3  = !r_w3_vld  || en_w4;
    assign en_w2  = !r_w2_vld  || en_w3;
    assign en_w1  = !r_w1_vld  || en_w2;
    assign en_rd  = !r_rd_vld  || en_w1;
    assign en_dv[NDIV] = !r_dv_vld[NDIV] || en_rd;
    for (genvar k = 0; k < NDIV; k++) begin : g_en
        assign en_dv[k] = !r_dv_vld[k] || en_dv[k+1];
    end
    assign en_p1  = !r_p1_vld || en_dv[0];

    assign o_in_ready = en_p1;

    // stage P1: offsets from the principal point, sign and magnitude
    logic [16:0] n_dx;
    logic [16:0] n_dy;
    logic [16:0] n_adx;
    logic [16:0] n_ady;
    logic        n_ok;

    always_comb begin
        n_dx  = 17'(i_pixel_u) - 17'(r_pp[15:0]);
        n_dy  = 17'(i_pixel_v) - 17'(r_pp[31:16]);
        n_adx = n_dx[16] ? -n_dx : n_dx;
        n_ady = n_dy[16] ? -n_dy : n_dy;
        n_ok  = (i_depth_mm != 16'd0) &&
                (32'(i_joint_index) < 32'(dbw_pkg::NUM_KEYPOINTS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (en_p1) begin
            r_p1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p1) begin
            r_p1_ok  <= n_ok;
            r_p1_idx <= i_joint_index;
            r_p1_adx <= n_adx[15:0];
            r_p1_ady <= n_ady[15:0];
            r_p1_sx  <= n_dx[16];
            r_p1_sy  <= n_dy[16];
            r_p1_z   <= i_depth_mm;
        end
    end

    // stage DV0: numerator magnitudes |d| * z
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en_dv[0]) begin
            r_dv_vld[0] <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_dv[0]) begin
            r_dv_side[0].ok     <= r_p1_ok;
            r_dv_side[0].idx    <= r_p1_idx;
            r_dv_side[0].neg_x  <= r_p1_sx;
            r_dv_side[0].neg_y  <= r_p1_sy;
            r_dv_side[0].zero_x <= (r_p1_adx == 16'd0);
            r_dv_side[0].zero_y <= (r_p1_ady == 16'd0);
            r_dv_side[0].z      <= r_p1_z;
            r_dv_x[0].rem       <= '0;
            r_dv_y[0].rem       <= '0;
            r_dv_x[0].num       <= 32'(r_p1_adx) * 32'(r_p1_z);
            r_dv_y[0].num       <= 32'(r_p1_ady) * 32'(r_p1_z);
        end
    end

    // stages DV1..DV32: one quotient bit per stage
    for (genvar k = 1; k <= NDIV; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (en_dv[k]) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en_dv[k]) begin
                r_dv_side[k] <= r_dv_side[k-1];
                r_dv_x[k]    <= div_step(r_dv_x[k-1], fx);
                r_dv_y[k]    <= div_step(r_dv_y[k-1], fy);
            end
        end
    end

    // stage RD: rounding and sign of the camera point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (en_rd) begin
            r_rd_vld <= r_dv_vld[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_rd) begin
            r_rd_tail.ok  <= r_dv_side[NDIV].ok;
            r_rd_tail.idx <= r_dv_side[NDIV].idx;
            r_rd_c[0] <= div_finish(r_dv_x[NDIV], fx, r_dv_side[NDIV].neg_x,
                                    r_dv_side[NDIV].zero_x);
            r_rd_c[1] <= div_finish(r_dv_y[NDIV], fy, r_dv_side[NDIV].neg_y,
                                    r_dv_side[NDIV].zero_y);
            r_rd_c[2] <= 34'(r_dv_side[NDIV].z);
        end
    end

    // stage W1: rotation products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1_vld <= 1'b0;
        end else if (en_w1) begin
            r_w1_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_w1) begin
            r_w1_tail <= r_rd_tail;
            for (int i = 0; i < 3; i++) begin
                r_w1_c[i] <= r_rd_c[i];
                for (int j = 0; j < 3; j++) begin
                    r_w1_p[i][j] <= signed'(r_rot[i][16*j +: 16]) * r_rd_c[j];
                end
            end
        end
    end

    // stage W2: row sums, translation scaled to mm
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w2_vld <= 1'b0;
        end else if (en_w2) begin
            r_w2_vld <= r_w1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_w2) begin
            r_w2_tail <= r_w1_tail;
            for (int i = 0; i < 3; i++) begin
                r_w2_c[i]   <= r_w1_c[i];
                r_w2_s[i]   <= 52'(r_w1_p[i][0]) + 52'(r_w1_p[i][1]) + 52'(r_w1_p[i][2]);
                r_w2_t10[i] <= (20'(signed'(r_trans[16*i +: 16])) <<< 3) +
                               (20'(signed'(r_trans[16*i +: 16])) <<< 1);
            end
        end
    end

    // stage W3: divide by 2^14, half away from zero
    logic signed [51:0] n_w2_bias [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_w2_bias[i] = r_w2_s[i] + (r_w2_s[i][51] ? 52'sd8191 : 52'sd8192);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w3_vld <= 1'b0;
        end else if (en_w3) begin
            r_w3_vld <= r_w2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_w3) begin
            r_w3_tail <= r_w2_tail;
            for (int i = 0; i < 3; i++) begin
                r_w3_c[i]   <= r_w2_c[i];
                r_w3_r[i]   <= 38'(n_w2_bias[i] >>> 14);
                r_w3_t10[i] <= r_w2_t10[i];
            end
        end
    end

    // stage W4: add translation, pick frame, zero invalid points
    logic signed [38:0] n_w4_v [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!r_w3_tail.ok) begin
                n_w4_v[i] = '0;
            end else if (r_world) begin
                n_w4_v[i] = 39'(r_w3_r[i]) + 39'(r_w3_t10[i]);
            end else begin
                n_w4_v[i] = 39'(r_w3_c[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w4_vld <= 1'b0;
        end else if (en_w4) begin
            r_w4_vld <= r_w3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_w4) begin
            r_w4_tail <= r_w3_tail;
            for (int i = 0; i < 3; i++) begin
                r_w4_v[i] <= n_w4_v[i];
            end
        end
    end

    // output register: saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en_out) begin
            r_out_vld <= r_w4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_tail <= r_w4_tail;
            for (int i = 0; i < 3; i++) begin
                r_out_c[i] <= sat24(r_w4_v[i]);
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_point_index = r_out_tail.idx;
    assign o_point_valid = r_out_tail.ok;
    assign o_coord_x_mm  = r_out_c[0];
    assign o_coord_y_mm  = r_out_c[1];
    assign o_coord_z_mm  = r_out_c[2];

    // checks
    a_ready_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_in_ready
    ) else $error("input not ready although output register is empty");

    a_accept_enters_pipe: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_p1_vld
    ) else $error("accepted request did not enter the first stage");

    a_div_tail_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_vld[NDIV] && !en_rd) |=>
            (r_dv_vld[NDIV] && $stable(r_dv_x[NDIV]) && $stable(r_dv_y[NDIV]))
    ) else $error("last divider stage changed while stalled");

    a_invalid_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_tail.ok) |->
            (o_coord_x_mm == '0 && o_coord_y_mm == '0 && o_coord_z_mm == '0)
    ) else $error("invalid point carries nonzero coordinates");

endmodule

### tb/testbench.sv
// Self-checking testbench for the keypoint back-projection and world transform block.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_REGS    = int'(dbw_pkg::CFG_WORLD_MODE) + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 104;

    typedef struct packed {
        logic               index;
        logic [3:0]         joint;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } t_world_point;

    // Predicts each keypoint result from its own register copy and checks results in order.
    class projection_board;
        t_world_point pending_points[$];
        logic [47:0]  regs [NUM_REGS];
        int           errors;

        function new();
            regs[dbw_pkg::CFG_FOCAL_LENGTHS]   = dbw_pkg::FOCAL_RST;
            regs[dbw_pkg::CFG_PRINCIPAL_POINT] = {16'd0, dbw_pkg::PP_RST};
            regs[dbw_pkg::CFG_ROTATION_ROW_A]  = dbw_pkg::ROT_A_RST;
            regs[dbw_pkg::CFG_ROTATION_ROW_B]  = dbw_pkg::ROT_B_RST;
            regs[dbw_pkg::CFG_ROTATION_ROW_C]  = dbw_pkg::ROT_C_RST;
            regs[dbw_pkg::CFG_TRANSLATION_CM]  = dbw_pkg::TRANS_RST;
            regs[dbw_pkg::CFG_WORLD_MODE]      = 48'd0;
            errors = 0;
        endfunction

        function void write_register(dbw_pkg::t_cfg_index r, logic [47:0] data);
            case (r)
                dbw_pkg::CFG_PRINCIPAL_POINT: regs[r] = {16'd0, data[31:0]};
                dbw_pkg::CFG_WORLD_MODE:      regs[r] = {47'd0, data[0]};
                default:                      regs[r] = data;
            endcase
        endfunction

        // nearest, ties away from zero; a zero divisor saturates by the numerator's sign
        function longint divide_round(longint num, longint den);
            longint mag;
            longint q;
            if (den == 0) begin
                if (num == 0) return 0;
                return (num < 0) ? longint'(dbw_pkg::COORD_MIN) : longint'(dbw_pkg::COORD_MAX);
            end
            mag = (num < 0) ? -num : num;
            q = (mag * 2 + den) / (den * 2);
            return (num < 0) ? -q : q;
        endfunction

        function longint rotate_row(logic [47:0] row, longint x, longint y, longint z);
            longint acc;
            longint mag;
            longint q;
            acc = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y
                + longint'($signed(row[47:32])) * z;
            mag = (acc < 0) ? -acc : acc;
            q = (mag + 8192) >> 14;
            return (acc < 0) ? -q : q;
        endfunction

        function logic signed [23:0] saturate(longint v);
            if (v > longint'(dbw_pkg::COORD_MAX)) return dbw_pkg::COORD_MAX;
            if (v < longint'(dbw_pkg::COORD_MIN)) return dbw_pkg::COORD_MIN;
            return v[23:0];
        endfunction

        function void project_keypoint(logic [3:0] joint, logic [15:0] u, logic [15:0] v,
                                       logic [15:0] depth);
            t_world_point p;
            logic [47:0]  trans;
            longint cam_x;
            longint cam_y;
            longint cam_z;
            longint cx;
            longint cy;
            longint fx;
            longint fy;
            longint wx;
            longint wy;
            longint wz;
            p.joint = joint;
            p.index = (depth != 0) && (joint < dbw_pkg::NUM_KEYPOINTS);
            p.x = '0;
            p.y = '0;
            p.z = '0;
            if (p.index) begin
                cx = longint'(regs[dbw_pkg::CFG_PRINCIPAL_POINT][15:0]);
                cy = longint'(regs[dbw_pkg::CFG_PRINCIPAL_POINT][31:16]);
                fx = longint'(regs[dbw_pkg::CFG_FOCAL_LENGTHS][23:0]);
                fy = longint'(regs[dbw_pkg::CFG_FOCAL_LENGTHS][47:24]);
                cam_z = longint'(depth);
                cam_x = divide_round((longint'(u) - cx) * cam_z, fx);
                cam_y = divide_round((longint'(v) - cy) * cam_z, fy);
                if (regs[dbw_pkg::CFG_WORLD_MODE][0]) begin
                    // translation is in cm, scale to mm
                    trans = regs[dbw_pkg::CFG_TRANSLATION_CM];
                    wx = rotate_row(regs[dbw_pkg::CFG_ROTATION_ROW_A], cam_x, cam_y, cam_z)
                       + 10 * longint'($signed(trans[15:0]));
                    wy = rotate_row(regs[dbw_pkg::CFG_ROTATION_ROW_B], cam_x, cam_y, cam_z)
                       + 10 * longint'($signed(trans[31:16]));
                    wz = rotate_row(regs[dbw_pkg::CFG_ROTATION_ROW_C], cam_x, cam_y, cam_z)
                       + 10 * longint'($signed(trans[47:32]));
                    cam_x = wx;
                    cam_y = wy;
                    cam_z = wz;
                end
                p.x = saturate(cam_x);
                p.y = saturate(cam_y);
                p.z = saturate(cam_z);
            end
            pending_points = {pending_points, p};
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void match_point(t_world_point got);
            t_world_point want;
            if (pending_points.size() == 0) begin
                errors++;
                $display("%0t: point %0d arrived with nothing pending, expected none actual %0d",
                         $time, got.joint, got.joint);
                return;
            end
            want = pending_points.pop_front();
            compare_field("point_index", want.joint, got.joint);
            compare_field("point_valid", want.index, got.index);
            compare_field("coord_x_mm", want.x, got.x);
            compare_field("coord_y_mm", want.y, got.y);
            compare_field("coord_z_mm", want.z, got.z);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    dbw_pkg::t_cfg_index i_cfg_index = dbw_pkg::CFG_FOCAL_LENGTHS;
    logic [47:0]         i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [3:0]          i_joint_index = '0;
    logic [15:0]         i_pixel_u = '0;
    logic [15:0]         i_pixel_v = '0;
    logic [15:0]         i_depth_mm = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [3:0]          o_point_index;
    logic                o_point_valid;
    logic signed [23:0]  o_coord_x_mm;
    logic signed [23:0]  o_coord_y_mm;
    logic signed [23:0]  o_coord_z_mm;

    projection_board board = new();
    logic [47:0]     staged [NUM_REGS];
    bit              sender_steady = 1'b0;
    bit              receiver_steady = 1'b0;
    int unsigned     cycle_count = 0;

    depth_backprojection_to_world u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [23:0] draw_focal_length();
        case ($urandom_range(0, 9))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(1, 31));
            3, 4:    return 24'($urandom);
            default: return 24'(16 * $urandom_range(200, 1500));
        endcase
    endfunction

    function automatic logic [15:0] draw_rotation_entry();
        case ($urandom_range(0, 5))
            0:       return 16'h4000;
            1:       return 16'hC000;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_keypoint(logic [3:0] joint, logic [15:0] u, logic [15:0] v,
                                 logic [15:0] depth);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_joint_index <= joint;
        i_pixel_u     <= u;
        i_pixel_v     <= v;
        i_depth_mm    <= depth;
        do @(posedge i_clk); while (!o_in_ready);
        board.project_keypoint(joint, u, v, depth);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_points.size() != 0) @(posedge i_clk);
    endtask

    // write every register from staged, keeping the request up between writes
    task automatic program_registers();
        i_cfg_valid <= 1'b1;
        for (int r = 0; r < NUM_REGS; r++) begin
            i_cfg_index <= dbw_pkg::t_cfg_index'(r);
            i_cfg_data  <= staged[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            board.write_register(dbw_pkg::t_cfg_index'(r), staged[r]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int          stall;
        t_world_point got;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = receiver_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.joint = o_point_index;
            got.index = o_point_valid;
            got.x     = o_coord_x_mm;
            got.y     = o_coord_y_mm;
            got.z     = o_coord_z_mm;
            board.match_point(got);
        end
    end

    initial begin
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] depth;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default registers: unit focal lengths, camera frame
        send_keypoint(4'd0, 16'h0000, 16'h0000, 16'h0000);
        send_keypoint(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_keypoint(4'd1, 16'h0000, 16'h0000, 16'h0001);
        send_keypoint(4'd2, 16'h0008, 16'h0018, 16'h0001);
        send_keypoint(4'd3, 16'h0007, 16'h0009, 16'h0001);
        send_keypoint(4'd4, 16'hFFFF, 16'h0000, 16'h0000);
        send_keypoint(4'd5, 16'h1000, 16'h2000, 16'd1000);
        send_keypoint(4'd6, 16'hFFFF, 16'h0000, 16'h0001);
        send_keypoint(4'd7, 16'h0123, 16'hFEDC, 16'hA5A5);
        send_keypoint(4'd8, 16'hAAAA, 16'h5555, 16'h00FF);
        send_keypoint(4'd9, 16'h5555, 16'hAAAA, 16'hFF00);
        send_keypoint(4'd10, 16'h8000, 16'h8000, 16'h8000);
        send_keypoint(4'd11, 16'h0010, 16'h0010, 16'hFFFF);
        send_keypoint(4'd12, 16'h0100, 16'h0100, 16'h8000);
        hold_until_drained();

        // zero focal lengths, far principal point, most negative rotation and offset
        staged[dbw_pkg::CFG_FOCAL_LENGTHS]   = 48'h0;
        staged[dbw_pkg::CFG_PRINCIPAL_POINT] = 48'hFFFF_FFFF_FFFF;
        staged[dbw_pkg::CFG_ROTATION_ROW_A]  = 48'h8000_8000_8000;
        staged[dbw_pkg::CFG_ROTATION_ROW_B]  = 48'h8000_8000_8000;
        staged[dbw_pkg::CFG_ROTATION_ROW_C]  = 48'h8000_8000_8000;
        staged[dbw_pkg::CFG_TRANSLATION_CM]  = 48'h8000_8000_8000;
        staged[dbw_pkg::CFG_WORLD_MODE]      = 48'hFFFF_FFFF_FFFF;
        program_registers();
        send_keypoint(4'd0, 16'hFFFF, 16'hFFFF, 16'd500);
        send_keypoint(4'd1, 16'h0000, 16'h0000, 16'd500);
        send_keypoint(4'd2, 16'h1234, 16'hFFFF, 16'hFFFF);
        send_keypoint(4'd3, 16'h0000, 16'hFFFF, 16'h0001);
        hold_until_drained();

        // widest focal lengths, most positive rotation and offset
        staged[dbw_pkg::CFG_FOCAL_LENGTHS]   = 48'hFFFF_FFFF_FFFF;
        staged[dbw_pkg::CFG_PRINCIPAL_POINT] = 48'h0;
        staged[dbw_pkg::CFG_ROTATION_ROW_A]  = 48'h7FFF_7FFF_7FFF;
        staged[dbw_pkg::CFG_ROTATION_ROW_B]  = 48'h7FFF_7FFF_7FFF;
        staged[dbw_pkg::CFG_ROTATION_ROW_C]  = 48'h7FFF_7FFF_7FFF;
        staged[dbw_pkg::CFG_TRANSLATION_CM]  = 48'h7FFF_7FFF_7FFF;
        staged[dbw_pkg::CFG_WORLD_MODE]      = 48'h1;
        program_registers();
        send_keypoint(4'd13, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_keypoint(4'd14, 16'h0000, 16'h0000, 16'hFFFF);
        send_keypoint(4'd15, 16'h4000, 16'h0001, 16'h0001);
        send_keypoint(4'd0, 16'h8000, 16'h8000, 16'h8000);
        hold_until_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            staged[dbw_pkg::CFG_FOCAL_LENGTHS]   = {draw_focal_length(), draw_focal_length()};
            staged[dbw_pkg::CFG_PRINCIPAL_POINT] = {16'($urandom), 32'($urandom)};
            staged[dbw_pkg::CFG_ROTATION_ROW_A]  = {draw_rotation_entry(),
                                                    draw_rotation_entry(),
                                                    draw_rotation_entry()};
            staged[dbw_pkg::CFG_ROTATION_ROW_B]  = {draw_rotation_entry(),
                                                    draw_rotation_entry(),
                                                    draw_rotation_entry()};
            staged[dbw_pkg::CFG_ROTATION_ROW_C]  = {draw_rotation_entry(),
                                                    draw_rotation_entry(),
                                                    draw_rotation_entry()};
            staged[dbw_pkg::CFG_TRANSLATION_CM]  = {16'($urandom), 32'($urandom)};
            staged[dbw_pkg::CFG_WORLD_MODE]      = {16'($urandom), 31'($urandom),
                                                    1'($urandom_range(0, 1))};
            program_registers();
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // let the pipeline run empty once in the middle of a phase
                if (phase == 4 && k == PHASE_ITEMS / 2) hold_until_drained();
                u = 16'($urandom);
                v = 16'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    u = board.regs[dbw_pkg::CFG_PRINCIPAL_POINT][15:0]
                        + 16'($urandom_range(0, 32)) - 16'd16;
                    v = board.regs[dbw_pkg::CFG_PRINCIPAL_POINT][31:16]
                        + 16'($urandom_range(0, 32)) - 16'd16;
                end
                case ($urandom_range(0, 15))
                    0:       depth = 16'h0000;
                    1:       depth = 16'hFFFF;
                    2:       depth = 16'h0001;
                    3, 4, 5, 6, 7, 8: depth = 16'($urandom_range(300, 5000));
                    default: depth = 16'($urandom);
                endcase
                send_keypoint(4'($urandom_range(0, 15)), u, v, depth);
            end
            hold_until_drained();
        end

        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        repeat (60) @(posedge i_clk);
        if (board.errors == 0 && board.pending_points.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### depth_backprojection_to_world.f
rtl/core/dbw_pkg.sv
rtl/core/depth_backprojection_to_world.sv
tb/testbench.sv
